// ===== hw/rtl/rrq_pkg.sv =====
// Types and codes shared by the ranked ready queue modules.
package rrq_pkg;

    localparam logic [2:0] MODE_APPEND = 3'd0;
    localparam logic [2:0] MODE_INSERT = 3'd1;
    localparam logic [2:0] MODE_POP    = 3'd2;
    localparam logic [2:0] MODE_REMOVE = 3'd3;
    localparam logic [2:0] MODE_SEARCH = 3'd4;

    localparam logic [2:0] STATUS_OK       = 3'd0;
    localparam logic [2:0] STATUS_INVALID  = 3'd1;
    localparam logic [2:0] STATUS_DUP      = 3'd2;
    localparam logic [2:0] STATUS_EMPTY    = 3'd3;
    localparam logic [2:0] STATUS_NOTFOUND = 3'd4;
    localparam logic [2:0] STATUS_FULL     = 3'd5;

    localparam logic [7:0] ID_INVALID = 8'd0;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] rank;
    } t_entry;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  out_id;
        logic [15:0] out_rank;
        logic [4:0]  occupancy;
    } t_result;

endpackage

// ===== hw/rtl/rrq_ifs.sv =====
// Request and response channel interfaces of the ranked ready queue.
interface rrq_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [7:0]  task_id;
    logic [15:0] task_rank;

    modport source (output valid, output mode, output task_id, output task_rank, input ready);
    modport sink (input valid, input mode, input task_id, input task_rank, output ready);
endinterface

interface rrq_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  out_id;
    logic [15:0] out_rank;
    logic [4:0]  occupancy;

    modport source (output valid, output status, output out_id, output out_rank,
                    output occupancy, input ready);
    modport sink (input valid, input status, input out_id, input out_rank,
                  input occupancy, output ready);
endinterface

// ===== hw/rtl/ranked_ready_queue.sv =====
// Top level of the ranked ready queue: sequencer, slot memory and response register.
//
// A bounded queue of task identifiers with ranks, kept in position order with the head in
// slot zero. Each request beat appends, inserts in rank order (after all equal ranks), pops
// the head, removes by identifier or searches, and yields exactly one response beat with a
// status, the entry concerned and the occupancy. Requests are handled one at a time through the
// slot memory: a request first scans the entries held and, if it writes the queue, then shifts
// the entries that move one slot at a time and writes the new entry, before the response goes
// to the output register. Requests settled up front (invalid identifier, pop or remove on an
// empty queue, unused mode, which answers OK) skip the scan. The output register lets the next
// request be accepted while a response still waits to be taken.
module ranked_ready_queue #(
    parameter int CAPACITY = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rrq_req_if.sink   i_req,
    rrq_rsp_if.source o_rsp
);
    import rrq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic          we;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;
    logic [AW-1:0] rd_addr;
    t_entry        rd_data;
    logic          res_valid;
    t_result       res;
    logic          res_ready;

    logic          r_out_vld;
    t_result       r_out;

    rrq_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_we        (we),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    rrq_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign res_ready = !r_out_vld || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_vld <= 1'b1;
            r_out     <= res;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.status    = r_out.status;
    assign o_rsp.out_id    = r_out.out_id;
    assign o_rsp.out_rank  = r_out.out_rank;
    assign o_rsp.occupancy = r_out.occupancy;

endmodule

// ===== hw/rtl/rrq_ram.sv =====
// Slot memory of the queue: one write port and one registered read port.
module rrq_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_wr_addr,
    input  rrq_pkg::t_entry   i_wr_data,
    input  logic [AW-1:0]     i_rd_addr,
    output rrq_pkg::t_entry   o_rd_data
);
    import rrq_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/rrq_ctrl.sv =====
// Sequencer that scans and shifts the queue slots one per cycle.
module rrq_ctrl #(
    parameter int CAPACITY = 16,
    parameter int AW       = 4,
    parameter int CW       = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    rrq_req_if.sink            i_req,
    output logic               o_we,
    output logic [AW-1:0]      o_wr_addr,
    output rrq_pkg::t_entry    o_wr_data,
    output logic [AW-1:0]      o_rd_addr,
    input  rrq_pkg::t_entry    i_rd_data,
    output logic               o_res_valid,
    output rrq_pkg::t_result   o_res,
    input  logic               i_res_ready
);
    import rrq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_RESP
    } t_state;

    t_state       r_state;
    logic [2:0]   r_mode;
    logic [7:0]   r_id;
    logic [15:0]  r_rank;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_iss;
    logic         r_pend;
    logic [CW-1:0] r_pidx;
    logic         r_found;
    logic [CW-1:0] r_fpos;
    logic [7:0]   r_fid;
    logic [15:0]  r_frank;
    logic         r_gt;
    logic [CW-1:0] r_ipos;
    logic         r_up;
    logic [CW-1:0] r_pos;
    logic [2:0]   r_status;
    logic [7:0]   r_oid;
    logic [15:0]  r_orank;

    logic          issue;
    logic          done;
    logic          match;
    logic [CW-1:0] iss_m1;
    logic [CW-1:0] pidx_p1;
    logic [CW-1:0] pidx_m1;
    logic [CW-1:0] issue_idx;
    logic [CW+4:0] cnt_ext;
    logic          needs_id;

    assign iss_m1  = r_iss - 1'b1;
    assign pidx_p1 = r_pidx + 1'b1;
    assign pidx_m1 = r_pidx - 1'b1;
    assign cnt_ext = {5'b0, r_cnt};

    assign needs_id = (i_req.mode == MODE_APPEND) || (i_req.mode == MODE_INSERT)
                   || (i_req.mode == MODE_REMOVE) || (i_req.mode == MODE_SEARCH);

    always_comb begin
        issue     = 1'b0;
        issue_idx = r_iss;
        o_we      = 1'b0;
        o_wr_addr = pidx_p1[AW-1:0];
        o_wr_data = i_rd_data;
        case (r_state)
            ST_SCAN: begin
                issue = r_iss < r_cnt;
            end
            ST_SHIFT: begin
                if (r_up) begin
                    issue     = r_iss > r_pos;
                    issue_idx = iss_m1;
                    if (r_pend) begin
                        o_we = 1'b1;
                    end else if (!issue) begin
                        o_we      = 1'b1;
                        o_wr_addr = r_pos[AW-1:0];
                        o_wr_data = '{id: r_id, rank: r_rank};
                    end
                end else begin
                    issue     = r_iss < r_cnt;
                    o_wr_addr = pidx_m1[AW-1:0];
                    o_we      = r_pend;
                end
            end
            default: begin
                issue = 1'b0;
            end
        endcase
        done  = !issue && !r_pend;
        match = (r_mode == MODE_POP) ? (r_pidx == '0) : (i_rd_data.id == r_id);
    end

    assign o_rd_addr     = issue_idx[AW-1:0];
    assign i_req.ready   = (r_state == ST_IDLE);
    assign o_res_valid   = (r_state == ST_RESP);
    assign o_res.status    = r_status;
    assign o_res.out_id    = r_oid;
    assign o_res.out_rank  = r_orank;
    assign o_res.occupancy = cnt_ext[4:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_req.valid) begin
                        r_mode   <= i_req.mode;
                        r_id     <= i_req.task_id;
                        r_rank   <= i_req.task_rank;
                        r_iss    <= '0;
                        r_pend   <= 1'b0;
                        r_found  <= 1'b0;
                        r_gt     <= 1'b0;
                        r_oid    <= '0;
                        r_orank  <= '0;
                        r_status <= STATUS_OK;
                        if (needs_id && i_req.task_id == ID_INVALID) begin
                            r_status <= STATUS_INVALID;
                            r_state  <= ST_RESP;
                        end else if ((i_req.mode == MODE_POP || i_req.mode == MODE_REMOVE)
                                     && r_cnt == '0) begin
                            r_status <= STATUS_EMPTY;
                            r_state  <= ST_RESP;
                        end else if (needs_id || i_req.mode == MODE_POP) begin
                            r_state <= ST_SCAN;
                        end else begin
                            r_state <= ST_RESP;
                        end
                    end
                end
                ST_SCAN: begin
                    r_pend <= issue;
                    r_pidx <= issue_idx;
                    if (issue) begin
                        r_iss <= r_iss + 1'b1;
                    end
                    if (r_pend) begin
                        if (match && !r_found) begin
                            r_found <= 1'b1;
                            r_fpos  <= r_pidx;
                            r_fid   <= i_rd_data.id;
                            r_frank <= i_rd_data.rank;
                        end
                        if (i_rd_data.rank > r_rank && !r_gt) begin
                            r_gt   <= 1'b1;
                            r_ipos <= r_pidx;
                        end
                    end
                    if (done) begin
                        case (r_mode)
                            MODE_APPEND, MODE_INSERT: begin
                                if (r_found) begin
                                    r_status <= STATUS_DUP;
                                    r_state  <= ST_RESP;
                                end else if (r_cnt >= CW'(CAPACITY)) begin
                                    r_status <= STATUS_FULL;
                                    r_state  <= ST_RESP;
                                end else begin
                                    r_up    <= 1'b1;
                                    r_pos   <= (r_mode == MODE_INSERT && r_gt) ? r_ipos : r_cnt;
                                    r_iss   <= r_cnt;
                                    r_state <= ST_SHIFT;
                                end
                            end
                            MODE_POP, MODE_REMOVE: begin
                                if (r_found) begin
                                    r_oid   <= r_fid;
                                    r_orank <= r_frank;
                                    r_up    <= 1'b0;
                                    r_pos   <= r_fpos;
                                    r_iss   <= r_fpos + 1'b1;
                                    r_state <= ST_SHIFT;
                                end else begin
                                    r_status <= STATUS_NOTFOUND;
                                    r_state  <= ST_RESP;
                                end
                            end
                            MODE_SEARCH: begin
                                if (r_found) begin
                                    r_oid   <= r_fid;
                                    r_orank <= r_frank;
                                end else begin
                                    r_status <= STATUS_NOTFOUND;
                                end
                                r_state <= ST_RESP;
                            end
                            default: begin
                                r_state <= ST_RESP;
                            end
                        endcase
                    end
                end
                ST_SHIFT: begin
                    r_pend <= issue;
                    r_pidx <= issue_idx;
                    if (issue) begin
                        r_iss <= r_up ? iss_m1 : r_iss + 1'b1;
                    end
                    if (done) begin
                        r_cnt   <= r_up ? r_cnt + 1'b1 : r_cnt - 1'b1;
                        r_state <= ST_RESP;
                    end
                end
                ST_RESP: begin
                    if (i_res_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
